### rtl/aap_pkg.sv
// Shared constants for the adaptive average pooling block.
`default_nettype none
package aap_pkg;
  localparam int MAX_LENGTH_DEF   = 4096;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int CFG_W            = 13;
  localparam int RUN_LIMIT        = 64;
  localparam int FIFO_DEPTH       = 4;
  localparam logic REG_IN_LENGTH  = 1'b0;
  localparam logic REG_OUT_LENGTH = 1'b1;
endpackage
`default_nettype wire

### rtl/adaptive_average_pool_1d_top.sv
// Top level of the 1D adaptive average pooling block.
// Samples of one line arrive on the s_ channel, one per transaction; for each
// output window the block emits the rounded mean of its samples on the m_
// channel once the window's last sample has arrived, in window order.
// in_length and out_length are written on the cfg port; a write restarts the
// line and the block is busy while it derives the window step in ST_LOAD and
// ST_DIV. Reset loads both lengths with 1 and runs the same setup, so s_tready
// is low for that time after reset.
// The front end takes a sample in ST_IDLE and then, in ST_EMIT, queues each
// window that ends on it before it takes the next sample. Each window is
// queued to the back end, whose bit-serial divider works on one result at a
// time and takes the next window from the queue only once the last result has
// gone into the output register.
// Results wait in the output register while the receiver stalls; the queue
// then fills and the front end stops taking samples. A line wraps by itself
// after its last sample.
`default_nettype none
module adaptive_average_pool_1d_top #(
  parameter int MAX_LENGTH   = aap_pkg::MAX_LENGTH_DEF,
  parameter int SAMPLE_WIDTH = aap_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_wen,
  input  wire logic                                  cfg_addr,
  input  wire logic [aap_pkg::CFG_W-1:0]             cfg_wdata,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,  // sample
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // average, window_index
  output logic [((SAMPLE_WIDTH+$clog2(MAX_LENGTH)+7)/8)*8-1:0] m_tdata,
  output logic                                       m_tlast,  // last_of_run
  output logic                                       m_tuser   // last_of_line
);
  localparam int LW      = $clog2(MAX_LENGTH + 1);
  localparam int IW      = $clog2(MAX_LENGTH);
  localparam int SUM_W   = SAMPLE_WIDTH + LW;
  localparam int ENTRY_W = SUM_W + LW + IW + 2;
  localparam int OUT_W   = ((SAMPLE_WIDTH + IW + 7) / 8) * 8;

  logic push, pop, full, empty;
  logic [ENTRY_W-1:0] push_data, pop_data;
  logic [SAMPLE_WIDTH-1:0] average;
  logic [IW-1:0] window_index;

  aap_front #(
    .MAX_LENGTH(MAX_LENGTH), .SAMPLE_WIDTH(SAMPLE_WIDTH), .ENTRY_W(ENTRY_W)
  ) u_front (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .in_sample(s_tdata[SAMPLE_WIDTH-1:0]),
    .push(push), .push_data(push_data), .full(full)
  );

  aap_fifo #(.WIDTH(ENTRY_W), .DEPTH(aap_pkg::FIFO_DEPTH)) u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data),
    .pop(pop), .pop_data(pop_data), .full(full), .empty(empty)
  );

  aap_back #(
    .MAX_LENGTH(MAX_LENGTH), .SAMPLE_WIDTH(SAMPLE_WIDTH), .ENTRY_W(ENTRY_W)
  ) u_back (
    .clk(clk), .rst(rst), .empty(empty), .pop_data(pop_data), .pop(pop),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_average(average), .out_index(window_index),
    .out_last_run(m_tlast), .out_last_line(m_tuser)
  );

  assign m_tdata = OUT_W'({window_index, average});
endmodule
`default_nettype wire

### rtl/aap_fifo.sv
// Small register queue between the window front end and the divider back end.
`default_nettype none
module aap_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  full,
  output logic                  empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full     = count == CW'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end
endmodule
`default_nettype wire

### rtl/aap_front.sv
// Front end: config, prefix sums and window bounds; queues one entry per finished window.
`default_nettype none
module aap_front #(
  parameter int MAX_LENGTH   = aap_pkg::MAX_LENGTH_DEF,
  parameter int SAMPLE_WIDTH = aap_pkg::SAMPLE_WIDTH_DEF,
  parameter int ENTRY_W      = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wen,
  input  wire logic                            cfg_addr,
  input  wire logic [aap_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]  in_sample,
  output logic                                 push,
  output logic [ENTRY_W-1:0]                   push_data,
  input  wire logic                            full
);
  localparam int LW    = $clog2(MAX_LENGTH + 1);
  localparam int QW    = LW + 1;
  localparam int IW    = $clog2(MAX_LENGTH);
  localparam int SUM_W = SAMPLE_WIDTH + LW;
  localparam int CW    = $clog2(LW + 1);

  typedef enum logic [1:0] {ST_LOAD, ST_DIV, ST_IDLE, ST_EMIT} state_t;
  state_t state;

  logic [aap_pkg::CFG_W-1:0] in_len, out_len;
  logic [LW-1:0] n_eff, m_eff, qn, rn, dvd, rem, p, nw, sr, er;
  logic [CW-1:0] cnt;
  logic [QW-1:0] sq, eq;
  logic signed [SUM_W-1:0] sum, prev, cap0;

  logic [31:0] n_c, m_c;
  logic [LW:0] dt, sr_a, er_a;
  logic dge, s_wrap, e_wrap, hit, more, at_start;
  logic [LW-1:0] sr_n, er_n;
  logic [QW-1:0] sq_n, eq_n, end_cur, end_nx, pos1;
  logic signed [SUM_W-1:0] diff;
  logic [LW-1:0] len;
  logic last_line;

  always_comb begin
    n_c = 32'(in_len);
    if (n_c == 32'd0) n_c = 32'd1;
    if (n_c > 32'(MAX_LENGTH)) n_c = 32'(MAX_LENGTH);
    m_c = 32'(out_len);
    if (m_c == 32'd0) m_c = 32'd1;
    if (m_c > 32'(MAX_LENGTH)) m_c = 32'(MAX_LENGTH);
    if (m_c > 32'(aap_pkg::RUN_LIMIT) * n_c) m_c = 32'(aap_pkg::RUN_LIMIT) * n_c;
  end

  assign dt  = {rem, dvd[LW-1]};
  assign dge = dt >= {1'b0, m_eff};

  always_comb begin
    sr_a   = {1'b0, sr} + {1'b0, rn};
    s_wrap = sr_a >= {1'b0, m_eff};
    sr_n   = s_wrap ? LW'(sr_a - {1'b0, m_eff}) : sr_a[LW-1:0];
    sq_n   = sq + QW'(qn) + QW'(s_wrap);
    er_a   = {1'b0, er} + {1'b0, rn};
    e_wrap = er_a >= {1'b0, m_eff};
    er_n   = e_wrap ? LW'(er_a - {1'b0, m_eff}) : er_a[LW-1:0];
    eq_n   = eq + QW'(qn) + QW'(e_wrap);
    end_cur = eq + QW'(er != '0);
    end_nx  = eq_n + QW'(er_n != '0);
    pos1    = QW'(p) + 1'b1;
    hit     = (nw < m_eff) && (end_cur == pos1);
    more    = (QW'(nw) + 1'b1 < QW'(m_eff)) && (end_nx == pos1);
    at_start = sq == QW'(p);
    diff    = sum - (at_start ? prev : cap0);
    len     = LW'(end_cur - sq);
    last_line = QW'(nw) + 1'b1 == QW'(m_eff);
  end

  assign in_ready  = state == ST_IDLE;
  assign push      = (state == ST_EMIT) && hit && !full;
  assign push_data = ENTRY_W'({last_line, !more, nw[IW-1:0], len, diff});

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      in_len  <= aap_pkg::CFG_W'(1);
      out_len <= aap_pkg::CFG_W'(1);
    end else begin
      if (cfg_wen) begin
        if (cfg_addr == aap_pkg::REG_IN_LENGTH) in_len <= cfg_wdata;
        else in_len <= in_len;
        if (cfg_addr == aap_pkg::REG_OUT_LENGTH) out_len <= cfg_wdata;
        state <= ST_LOAD;
      end else begin
        unique case (state)
          ST_LOAD: begin
            n_eff <= LW'(n_c);
            m_eff <= LW'(m_c);
            dvd   <= LW'(n_c);
            rem   <= '0;
            cnt   <= '0;
            state <= ST_DIV;
          end
          ST_DIV: begin
            rem <= dge ? LW'(dt - {1'b0, m_eff}) : dt[LW-1:0];
            dvd <= {dvd[LW-2:0], dge};
            cnt <= cnt + 1'b1;
            if (cnt == CW'(LW - 1)) begin
              qn    <= {dvd[LW-2:0], dge};
              rn    <= dge ? LW'(dt - {1'b0, m_eff}) : dt[LW-1:0];
              eq    <= QW'({dvd[LW-2:0], dge});
              er    <= dge ? LW'(dt - {1'b0, m_eff}) : dt[LW-1:0];
              sum   <= '0;
              prev  <= '0;
              cap0  <= '0;
              p     <= '0;
              nw    <= '0;
              sq    <= '0;
              sr    <= '0;
              state <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (in_valid) begin
              prev <= sum;
              sum  <= sum + SUM_W'(in_sample);
              if (at_start) cap0 <= sum;
              state <= ST_EMIT;
            end
          end
          ST_EMIT: begin
            if (hit) begin
              if (!full) begin
                nw <= nw + 1'b1;
                sq <= sq_n;
                sr <= sr_n;
                eq <= eq_n;
                er <= er_n;
              end
            end else begin
              if (at_start) cap0 <= prev;
              if (pos1 >= QW'(n_eff)) begin
                sum  <= '0;
                prev <= '0;
                cap0 <= '0;
                p    <= '0;
                nw   <= '0;
                sq   <= '0;
                sr   <= '0;
                eq   <= QW'(qn);
                er   <= rn;
              end else begin
                p <= p + 1'b1;
              end
              state <= ST_IDLE;
            end
          end
          default: state <= ST_LOAD;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

### rtl/aap_back.sv
// Back end: rounded division of each window sum by its length, output register.
`default_nettype none
module aap_back #(
  parameter int MAX_LENGTH   = aap_pkg::MAX_LENGTH_DEF,
  parameter int SAMPLE_WIDTH = aap_pkg::SAMPLE_WIDTH_DEF,
  parameter int ENTRY_W      = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        empty,
  input  wire logic [ENTRY_W-1:0]          pop_data,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [SAMPLE_WIDTH-1:0]          out_average,
  output logic [$clog2(MAX_LENGTH)-1:0]    out_index,
  output logic                             out_last_run,
  output logic                             out_last_line
);
  localparam int LW    = $clog2(MAX_LENGTH + 1);
  localparam int IW    = $clog2(MAX_LENGTH);
  localparam int SUM_W = SAMPLE_WIDTH + LW;
  localparam int DW    = SUM_W + 2;
  localparam int CW    = $clog2(DW + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_HOLD} state_t;
  state_t state;

  logic signed [SUM_W-1:0] e_diff;
  logic [LW-1:0] e_len;
  logic [IW-1:0] e_idx;
  logic e_run, e_line;
  logic [SUM_W-1:0] e_mag;

  logic [DW-1:0] dvd;
  logic [LW:0] dsr, rem;
  logic [LW+1:0] dt;
  logic dge, neg, r_run, r_line;
  logic [IW-1:0] r_idx;
  logic [CW-1:0] cnt;
  logic [DW-1:0] sres;

  assign {e_line, e_run, e_idx, e_len, e_diff} = pop_data[SUM_W+LW+IW+1:0];
  assign e_mag = e_diff[SUM_W-1] ? SUM_W'(-e_diff) : SUM_W'(e_diff);
  assign dt    = {rem, dvd[DW-1]};
  assign dge   = dt >= {1'b0, dsr};
  assign sres  = neg ? -dvd : dvd;
  assign pop   = (state == ST_IDLE) && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (out_valid && out_ready) out_valid <= 1'b0;
          if (!empty) begin
            neg    <= e_diff[SUM_W-1];
            dvd    <= (DW'(e_mag) << 1) + DW'(e_len);
            dsr    <= {e_len, 1'b0};
            rem    <= '0;
            cnt    <= '0;
            r_idx  <= e_idx;
            r_run  <= e_run;
            r_line <= e_line;
            state  <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (out_valid && out_ready) out_valid <= 1'b0;
          rem <= dge ? (LW+1)'(dt - {1'b0, dsr}) : dt[LW:0];
          dvd <= {dvd[DW-2:0], dge};
          cnt <= cnt + 1'b1;
          if (cnt == CW'(DW - 1)) state <= ST_HOLD;
        end
        ST_HOLD: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            out_average   <= sres[SAMPLE_WIDTH-1:0];
            out_index     <= r_idx;
            out_last_run  <= r_run;
            out_last_line <= r_line;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
